### rtl/periodic_timer_slot_bank_top_macros.svh
// Assertion macros for the periodic timer slot bank.
// Included by the top level; no other dependencies.
`ifndef PERIODIC_TIMER_SLOT_BANK_TOP_MACROS_SVH
`define PERIODIC_TIMER_SLOT_BANK_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PTSB_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define PTSB_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define PTSB_ASSERT_IMP(label, clk, rst, a, c)
`define PTSB_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

### rtl/ptsb_pkg.sv
// Package for the periodic timer slot bank: word types, codes, states.
// No dependencies.
`timescale 1ns / 1ps
package ptsb_pkg;
  localparam int SLOTS     = 16;
  localparam int TICK_BITS = 16;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int LEN_W     = $clog2(SLOTS + 1);
  localparam logic HIGH_CLASS_SEL = 1'b1;

  typedef enum logic [2:0] {
    K_INIT = 3'd0, K_START = 3'd1, K_STOP = 3'd2, K_DESTROY = 3'd3, K_TICK = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_UNUSED = 3'd0, ST_CREATED = 3'd1, ST_STARTED = 3'd2,
    ST_STOPPED = 3'd3, ST_DESTROYED = 3'd4
  } life_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CMD, S_UNLINK, S_WALK, S_DONE
  } fsm_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [15:0] start_delay;
    logic [15:0] period;
    logic        high_class;
  } in_word_t;

  typedef struct packed {
    logic [3:0] out_slot;
    logic       fired;
    logic [2:0] slot_status;
    logic       accepted;
    logic       last;
  } out_word_t;
endpackage

### rtl/periodic_timer_slot_bank_top.sv
// Top level of the periodic timer slot bank: command sequencer and slot store.
// Depends on ptsb_pkg and periodic_timer_slot_bank_top_macros.svh.
`timescale 1ns / 1ps
`include "periodic_timer_slot_bank_top_macros.svh"
//
// Channel   Ports                   Handshake
// command   cmd (in_word_t)         start high while busy low
// result    res (out_word_t)        strobe high for one cycle, no stall
//
// A command is decoded and reported in S_CMD; stop and destroy of a started slot
// then remove it from its list in S_UNLINK. A tick walks the high list and then
// the low list: one shared decrement-and-compare unit visits one list entry per
// cycle, with a closing step per list, and S_DONE gives the closing result.
// Reset clears all slot state and both list lengths.
// The receiver cannot stall; each result is shown once with strobe.
module periodic_timer_slot_bank_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  ptsb_pkg::in_word_t  cmd,
  output logic                busy,
  output logic                strobe,
  output ptsb_pkg::out_word_t res
);
  import ptsb_pkg::*;

  fsm_t state, state_next;
  in_word_t cur;

  logic [TICK_BITS-1:0] count_left   [SLOTS];
  logic [TICK_BITS-1:0] delay_store  [SLOTS];
  logic [TICK_BITS-1:0] period_store [SLOTS];
  logic                 class_bit    [SLOTS];
  life_t                life_state   [SLOTS];
  logic [SLOT_W-1:0]    high_order   [SLOTS];
  logic [SLOT_W-1:0]    low_order    [SLOTS];
  logic [LEN_W-1:0]     high_len, low_len;

  // walk pointers: read index i, write index j, and which list
  logic [LEN_W-1:0] rd_i, wr_j;
  logic             walk_hi;

  // shared unit operands
  logic [SLOT_W-1:0]    w_slot;
  logic [TICK_BITS-1:0] w_dec;
  logic [TICK_BITS-1:0] w_per;
  logic                 w_zero;
  logic                 w_keep;
  logic [LEN_W-1:0]     w_len;
  logic [SLOT_W-1:0]    c_slot;
  life_t                c_life;

  // command decode: outcome of the held command
  logic                 cmd_acc;
  life_t                cmd_status;

  assign c_slot = cur.slot[SLOT_W-1:0];
  assign c_life = life_state[c_slot];
  assign w_len  = walk_hi ? high_len : low_len;
  assign w_slot = walk_hi ? high_order[rd_i[SLOT_W-1:0]] : low_order[rd_i[SLOT_W-1:0]];
  assign w_dec  = count_left[w_slot] - 1'b1;
  assign w_per  = period_store[w_slot];
  assign w_zero = (w_dec == '0);
  // keep the slot on its list unless it is a one-shot that just expired
  assign w_keep = !w_zero || (w_per != '0);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) state_next = (cmd.kind == K_TICK) ? S_WALK : S_CMD;
      S_CMD:    if ((cur.kind == K_STOP || cur.kind == K_DESTROY) &&
                    c_life == ST_STARTED) state_next = S_UNLINK;
                else state_next = S_IDLE;
      S_UNLINK: if (rd_i >= w_len) state_next = S_IDLE;
      S_WALK:   if (rd_i >= w_len && !walk_hi) state_next = S_DONE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Decide acceptance and the resulting life state; unknown kinds change nothing.
  always_comb begin
    cmd_acc    = 1'b0;
    cmd_status = c_life;
    case (cur.kind)
      K_INIT: if (c_life != ST_STARTED) begin
        cmd_acc    = 1'b1;
        cmd_status = ST_CREATED;
      end
      K_START: if (c_life == ST_CREATED || c_life == ST_STOPPED) begin
        cmd_acc    = 1'b1;
        cmd_status = ST_STARTED;
      end
      K_STOP: if (c_life == ST_STARTED) begin
        cmd_acc    = 1'b1;
        cmd_status = ST_STOPPED;
      end
      K_DESTROY: begin
        cmd_acc    = 1'b1;
        cmd_status = ST_DESTROYED;
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      strobe <= 1'b0;
      high_len <= '0;
      low_len <= '0;
      for (int k = 0; k < SLOTS; k++) begin
        count_left[k] <= '0; delay_store[k] <= '0; period_store[k] <= '0;
        class_bit[k] <= 1'b0; life_state[k] <= ST_UNUSED;
      end
    end else begin
      state <= state_next;
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          cur <= cmd;
          rd_i <= '0; wr_j <= '0;
          walk_hi <= 1'b1;
        end
        S_CMD: begin
          // report at once; list removal follows
          res.out_slot <= cur.slot;
          res.fired <= 1'b0;
          res.last <= 1'b1;
          res.accepted <= cmd_acc;
          res.slot_status <= cmd_status;
          strobe <= 1'b1;
          walk_hi <= class_bit[c_slot];
          if (cmd_acc) begin
            life_state[c_slot] <= cmd_status;
            case (cur.kind)
              K_INIT: begin
                delay_store[c_slot] <= cur.start_delay[TICK_BITS-1:0];
                period_store[c_slot] <= cur.period[TICK_BITS-1:0];
                count_left[c_slot] <= (cur.start_delay != '0) ?
                  cur.start_delay[TICK_BITS-1:0] : cur.period[TICK_BITS-1:0];
                class_bit[c_slot] <= (cur.high_class == HIGH_CLASS_SEL);
              end
              K_START: begin
                count_left[c_slot] <= (delay_store[c_slot] != '0) ?
                  delay_store[c_slot] : period_store[c_slot];
                // push front: shift the list up by one
                if (class_bit[c_slot]) begin
                  if (high_len < LEN_W'(SLOTS)) begin
                    for (int k = 1; k < SLOTS; k++) high_order[k] <= high_order[k-1];
                    high_order[0] <= c_slot;
                    high_len <= high_len + 1'b1;
                  end
                end else if (low_len < LEN_W'(SLOTS)) begin
                  for (int k = 1; k < SLOTS; k++) low_order[k] <= low_order[k-1];
                  low_order[0] <= c_slot;
                  low_len <= low_len + 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_UNLINK: begin
          // compact the list, dropping the addressed slot
          if (rd_i < w_len) begin
            if (w_slot != c_slot) begin
              if (walk_hi) high_order[wr_j[SLOT_W-1:0]] <= w_slot;
              else low_order[wr_j[SLOT_W-1:0]] <= w_slot;
              wr_j <= wr_j + 1'b1;
            end
            rd_i <= rd_i + 1'b1;
          end else if (walk_hi) high_len <= wr_j;
          else low_len <= wr_j;
        end
        S_WALK: begin
          if (rd_i < w_len) begin
            // decrement, or reload on expiry of a periodic slot
            count_left[w_slot] <= (w_zero && w_per != '0) ? w_per : w_dec;
            if (w_zero) begin
              res.out_slot <= 4'(w_slot);
              res.fired <= 1'b1;
              res.accepted <= 1'b1;
              res.last <= 1'b0;
              res.slot_status <= (w_per != '0) ? life_state[w_slot] : ST_STOPPED;
              strobe <= 1'b1;
              if (w_per == '0) life_state[w_slot] <= ST_STOPPED;
            end
            if (w_keep) begin
              if (walk_hi) high_order[wr_j[SLOT_W-1:0]] <= w_slot;
              else low_order[wr_j[SLOT_W-1:0]] <= w_slot;
              wr_j <= wr_j + 1'b1;
            end
            rd_i <= rd_i + 1'b1;
          end else begin
            // close this list; after the high list, move to the low list
            if (walk_hi) high_len <= wr_j;
            else low_len <= wr_j;
            walk_hi <= 1'b0;
            rd_i <= '0; wr_j <= '0;
          end
        end
        S_DONE: begin
          res.out_slot <= '0; res.fired <= 1'b0; res.slot_status <= ST_UNUSED;
          res.accepted <= 1'b1; res.last <= 1'b1;
          strobe <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  `PTSB_ASSERT_IMP(a_len_hi, clk, rst, 1'b1, high_len <= LEN_W'(SLOTS))
  `PTSB_ASSERT_IMP(a_len_lo, clk, rst, 1'b1, low_len <= LEN_W'(SLOTS))
  `PTSB_ASSERT_NXT(a_done_last, clk, rst, state == S_DONE, strobe && res.last)
  `PTSB_ASSERT_IMP(a_idle_quiet, clk, rst, state == S_IDLE && !start, !busy)
endmodule
